// File: sv/bpri_pkg.sv
// shared types, codes and constants of the bus panel reply injector
package bpri_pkg;

    // input item commands
    localparam logic [1:0] CMD_WORD  = 2'd0;
    localparam logic [1:0] CMD_SPEED = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // bus message codes
    localparam logic [8:0] START_WORD     = 9'h102;
    localparam logic [8:0] DEST_WORD      = 9'h101;
    localparam logic [8:0] PAGE_WRITE_LEN = 9'h011;
    localparam logic [8:0] MSG_POLL       = 9'd1;
    localparam logic [8:0] MSG_QUERY      = 9'd3;
    localparam logic [8:0] MSG_PAGE_WRITE = 9'd4;
    localparam logic [7:0] SUM_SEED       = 8'hFE;

    // result kinds
    localparam logic KIND_BUS  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // page layout
    localparam int PAGE_LEN    = 21;
    localparam int WORD_W      = 5;
    localparam int POLL_LEN    = 6;
    localparam int DETECT_WORD = 14;

    // panel detection
    localparam logic [8:0] LED_CODE    = 9'd1;
    localparam logic [3:0] DETECT_PAGE = 4'd2;
    localparam logic [3:0] LED_PAGE    = 4'd2;
    localparam logic [4:0] LED_SLOT    = 5'd12;
    localparam logic [3:0] TFT_PAGE    = 4'd0;
    localparam logic [4:0] TFT_SLOT    = 5'd8;

    typedef struct packed {
        logic [1:0] command;
        logic [8:0] bus_word;
        logic [7:0] fan_speed;
        logic [3:0] page_select;
        logic [4:0] word_select;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [8:0] data;
        logic       last;
        logic       relay_engaged;
        logic       panel_detected;
    } out_item_t;

    // framing status handed from the framer to the engine
    typedef struct packed {
        logic       complete;
        logic [8:0] len;
        logic [8:0] cmd;
        logic [8:0] addr;
    } msg_t;

    // fixed "changed" reply to a poll
    function automatic logic [8:0] poll_word(input logic [2:0] idx, input logic tft);
        logic [8:0] w;
        case (idx)
            3'd0:    w = DEST_WORD;
            3'd1:    w = 9'h002;
            3'd2:    w = 9'h002;
            3'd3:    w = tft ? 9'h082 : 9'h092;
            3'd4:    w = 9'h010;
            3'd5:    w = tft ? 9'h06D : 9'h07D;
            default: w = 9'h000;
        endcase
        return w;
    endfunction

endpackage

// File: sv/bpri_if.sv
// valid/ready channels for input items and result items
interface bpri_in_if;
    logic                valid;
    logic                ready;
    bpri_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bpri_out_if;
    logic                valid;
    logic                ready;
    bpri_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/bpri_ram.sv
// generic single write, single read ram with registered read data
module bpri_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/bpri_framer.sv
// message framing of received bus words into the receive buffer
module bpri_framer #(
    parameter int MSG_WORDS = 32,
    localparam int RX_AW = $clog2(MSG_WORDS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             word_valid,
    input  logic [8:0]       word,
    input  logic             rd_en,
    input  logic [RX_AW-1:0] rd_addr,
    output logic [8:0]       rd_data,
    output bpri_pkg::msg_t   msg
);

    localparam int CNT_W = $clog2(MSG_WORDS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             started_reg, started_next;
    logic [8:0]       len_reg, cmd_reg, addr_reg;

    logic             is_start;
    logic             we;
    logic [RX_AW-1:0] widx;
    logic [8:0]       len_eff;

    always_comb
    begin
        is_start = word_valid && (word == bpri_pkg::START_WORD);
        we = word_valid && (is_start || (started_reg && (count_reg < CNT_W'(MSG_WORDS))));
        widx = is_start ? '0 : count_reg[RX_AW-1:0];
        count_next = count_reg;
        started_next = started_reg || is_start;
        if (we)
        begin
            count_next = CNT_W'(widx) + 1'b1;
        end
        // the length word may be the one arriving right now
        len_eff = (widx == RX_AW'(1)) ? word : len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (widx == RX_AW'(1)))
        begin
            len_reg <= word;
        end
        if (we && (widx == RX_AW'(2)))
        begin
            cmd_reg <= word;
        end
        if (we && (widx == RX_AW'(3)))
        begin
            addr_reg <= word;
        end
    end

    bpri_ram #(
        .WIDTH (9),
        .DEPTH (MSG_WORDS)
    ) u_rx_ram (
        .clk   (clk),
        .we    (we),
        .waddr (widx),
        .wdata (word),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign msg.complete = we && (count_next > CNT_W'(1))
        && (10'(count_next) == (10'(len_eff) + 10'd4));
    assign msg.len = len_reg;
    assign msg.cmd = cmd_reg;
    assign msg.addr = addr_reg;

endmodule

// File: sv/bpri_engine.sv
// sequencer over the page store: page copy, checksum walk, replies and reads
module bpri_engine #(
    parameter int MSG_WORDS = 32,
    parameter int NUM_PAGES = 8,
    localparam int RX_AW = $clog2(MSG_WORDS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bpri_pkg::in_item_t  item,
    output logic                in_ready,
    input  bpri_pkg::msg_t      msg,
    output logic                rx_rd_en,
    output logic [RX_AW-1:0]    rx_rd_addr,
    input  logic [8:0]          rx_rd_data,
    output logic                out_valid,
    output bpri_pkg::out_item_t out_item,
    input  logic                out_ready
);

    localparam int PG_W     = $clog2(NUM_PAGES);
    localparam int PS_AW    = PG_W + bpri_pkg::WORD_W;
    localparam int PS_DEPTH = NUM_PAGES << bpri_pkg::WORD_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_COPY,
        ST_PATCH,
        ST_SUM_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic [1:0] {
        MODE_READ,
        MODE_POLL,
        MODE_PAGE
    } mode_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [4:0]          idx_reg, idx_next;
    logic [PS_AW-1:0]    clr_reg, clr_next;
    logic [7:0]          sum_reg, sum_next;
    logic                zero_reg, zero_next;
    logic                led_reg, led_next;
    logic [PG_W-1:0]     copy_pg_reg, copy_pg_next;
    logic                request_reg, request_next;
    logic [7:0]          speed_reg, speed_next;
    logic                detected_reg, detected_next;
    logic [3:0]          speed_page_reg, speed_page_next;
    logic [4:0]          speed_slot_reg, speed_slot_next;
    logic                out_valid_reg, out_valid_next;
    bpri_pkg::out_item_t out_item_reg, out_item_next;

    logic                ps_we;
    logic [PS_AW-1:0]    ps_waddr;
    logic [8:0]          ps_wdata;
    logic                ps_re;
    logic [PS_AW-1:0]    ps_raddr;
    logic [8:0]          ps_rdata;

    logic [PG_W-1:0]     sp;
    logic [5:0]          pos;
    logic [8:0]          patch_word;
    logic                rd_ok;

    always_comb
    begin
        sp = PG_W'(speed_page_reg);
        pos = 6'(speed_slot_reg) + 6'd4;
        if (idx_reg == 5'd0)
        begin
            patch_word = bpri_pkg::DEST_WORD;
        end
        else if ({1'b0, idx_reg} == pos)
        begin
            patch_word = {1'b0, speed_reg};
        end
        else
        begin
            patch_word = ps_rdata;
        end
        // words past the page length are never written and stay zero
        rd_ok = ({1'b0, item.page_select} < 5'(NUM_PAGES))
            && (7'(item.word_select) < 7'(MSG_WORDS))
            && (item.word_select < 5'(bpri_pkg::PAGE_LEN));
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        idx_next = idx_reg;
        clr_next = clr_reg;
        sum_next = sum_reg;
        zero_next = zero_reg;
        led_next = led_reg;
        copy_pg_next = copy_pg_reg;
        request_next = request_reg;
        speed_next = speed_reg;
        detected_next = detected_reg;
        speed_page_next = speed_page_reg;
        speed_slot_next = speed_slot_reg;
        out_valid_next = out_valid_reg;
        out_item_next = out_item_reg;

        ps_we = 1'b0;
        ps_waddr = clr_reg;
        ps_wdata = '0;
        ps_re = 1'b0;
        ps_raddr = {sp, idx_reg};
        rx_rd_en = 1'b0;
        rx_rd_addr = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ps_we = 1'b1;
                ps_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == PS_AW'(PS_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        bpri_pkg::CMD_WORD:
                        begin
                            if (msg.complete)
                            begin
                                state_next = ST_DECIDE;
                            end
                        end
                        bpri_pkg::CMD_SPEED:
                        begin
                            request_next = 1'b1;
                            speed_next = item.fan_speed;
                        end
                        bpri_pkg::CMD_READ:
                        begin
                            ps_re = 1'b1;
                            ps_raddr = {PG_W'(item.page_select), item.word_select};
                            zero_next = !rd_ok;
                            mode_next = MODE_READ;
                            state_next = ST_EMIT_LD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                if ((msg.cmd == bpri_pkg::MSG_PAGE_WRITE)
                    && (msg.addr < 9'(NUM_PAGES * 16))
                    && (msg.len == bpri_pkg::PAGE_WRITE_LEN))
                begin
                    copy_pg_next = msg.addr[PG_W+3:4];
                    rx_rd_en = 1'b1;
                    rx_rd_addr = '0;
                    state_next = ST_COPY;
                end
                else if (request_reg && (msg.cmd == bpri_pkg::MSG_POLL))
                begin
                    mode_next = MODE_POLL;
                    state_next = ST_EMIT_LD;
                end
                else if (request_reg && (msg.cmd == bpri_pkg::MSG_QUERY)
                    && (msg.addr == {1'b0, speed_page_reg, 4'b0000}))
                begin
                    sum_next = bpri_pkg::SUM_SEED;
                    ps_re = 1'b1;
                    ps_raddr = {sp, 5'd0};
                    state_next = ST_PATCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                ps_we = 1'b1;
                ps_waddr = {copy_pg_reg, idx_reg};
                ps_wdata = rx_rd_data;
                if (idx_reg == 5'(bpri_pkg::DETECT_WORD))
                begin
                    led_next = (rx_rd_data == bpri_pkg::LED_CODE);
                end
                if (idx_reg == 5'(bpri_pkg::PAGE_LEN - 1))
                begin
                    state_next = ST_IDLE;
                    if ((copy_pg_reg == PG_W'(bpri_pkg::DETECT_PAGE)) && !detected_reg)
                    begin
                        detected_next = 1'b1;
                        speed_page_next = led_reg ? bpri_pkg::LED_PAGE : bpri_pkg::TFT_PAGE;
                        speed_slot_next = led_reg ? bpri_pkg::LED_SLOT : bpri_pkg::TFT_SLOT;
                    end
                end
                else
                begin
                    rx_rd_en = 1'b1;
                    rx_rd_addr = RX_AW'(idx_reg + 5'd1);
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_PATCH:
            begin
                // write back the patched word and fold it into the checksum
                ps_we = 1'b1;
                ps_waddr = {sp, idx_reg};
                ps_wdata = patch_word;
                sum_next = sum_reg ^ patch_word[7:0];
                if (idx_reg == 5'(bpri_pkg::PAGE_LEN - 2))
                begin
                    state_next = ST_SUM_WR;
                end
                else
                begin
                    ps_re = 1'b1;
                    ps_raddr = {sp, idx_reg + 5'd1};
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_SUM_WR:
            begin
                ps_we = 1'b1;
                ps_waddr = {sp, 5'(bpri_pkg::PAGE_LEN - 1)};
                ps_wdata = {1'b0, sum_reg};
                idx_next = '0;
                mode_next = MODE_PAGE;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                ps_re = 1'b1;
                ps_raddr = {sp, idx_reg};
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.kind = bpri_pkg::KIND_BUS;
                    out_item_next.relay_engaged = request_reg;
                    out_item_next.panel_detected = detected_reg;
                    case (mode_reg)
                        MODE_READ:
                        begin
                            out_item_next.kind = bpri_pkg::KIND_READ;
                            out_item_next.data = zero_reg ? 9'd0 : ps_rdata;
                            out_item_next.last = 1'b1;
                            state_next = ST_IDLE;
                        end
                        MODE_POLL:
                        begin
                            out_item_next.data = bpri_pkg::poll_word(idx_reg[2:0],
                                speed_page_reg == bpri_pkg::TFT_PAGE);
                            out_item_next.last = (idx_reg == 5'(bpri_pkg::POLL_LEN - 1));
                            idx_next = idx_reg + 5'd1;
                            if (idx_reg == 5'(bpri_pkg::POLL_LEN - 1))
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        MODE_PAGE:
                        begin
                            out_item_next.data = ps_rdata;
                            out_item_next.last = (idx_reg == 5'(bpri_pkg::PAGE_LEN - 1));
                            idx_next = idx_reg + 5'd1;
                            if (idx_reg == 5'(bpri_pkg::PAGE_LEN - 1))
                            begin
                                request_next = 1'b0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_EMIT_RD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg <= MODE_READ;
            idx_reg <= '0;
            clr_reg <= '0;
            request_reg <= 1'b0;
            speed_reg <= '0;
            detected_reg <= 1'b0;
            speed_page_reg <= bpri_pkg::TFT_PAGE;
            speed_slot_reg <= bpri_pkg::TFT_SLOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            idx_reg <= idx_next;
            clr_reg <= clr_next;
            request_reg <= request_next;
            speed_reg <= speed_next;
            detected_reg <= detected_next;
            speed_page_reg <= speed_page_next;
            speed_slot_reg <= speed_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        zero_reg <= zero_next;
        led_reg <= led_next;
        copy_pg_reg <= copy_pg_next;
        out_item_reg <= out_item_next;
    end

    bpri_ram #(
        .WIDTH (9),
        .DEPTH (PS_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .re    (ps_re),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

`ifndef SYNTHESIS
    // a read result is always a run of one
    a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.kind == bpri_pkg::KIND_READ) |-> out_item_reg.last)
        else $error("read result without last");

    // bus replies only go out while a speed request is pending
    a_reply_relay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.kind == bpri_pkg::KIND_BUS)
        |-> out_item_reg.relay_engaged)
        else $error("bus reply without pending request");

    // nothing comes out during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing pass");

    // the request clears only on the last word of a page reply
    a_request_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(request_reg) |-> $past((state_reg == ST_EMIT_LD) && (mode_reg == MODE_PAGE)))
        else $error("request cleared outside page reply");

    // detection happens once and sticks
    a_detect_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(detected_reg))
        else $error("panel detection lost");
`endif

endmodule

// File: sv/bus_panel_reply_injector_core.sv
// top level of the bus panel reply injector
//
// Takes one item at a time and drops ready until its results are queued.
// After reset a clearing pass zeroes all NUM_PAGES*32 words of the page
// store (256 at the default) before the first item is taken. A bus word
// that does not complete a message and a fan speed request leave ready
// high; a page word read goes through a load state. A completed
// page-write message copies 21 words from the receive buffer, one per
// cycle. A poll answer has 6 words. A page query walks 20 words through
// the checksum, writes the checksum and then streams 21 words, each via a
// read state and a load state. The page store, with one write port, one
// read port and registered read, is visited one word per step; a stalled
// result port stalls the replies: one output register holds the next word.
module bus_panel_reply_injector_core #(
    parameter int MSG_WORDS = 32,
    parameter int NUM_PAGES = 8
) (
    input logic        clk,
    input logic        rst_n,
    bpri_in_if.sink    request,
    bpri_out_if.source result
);

    localparam int RX_AW = $clog2(MSG_WORDS);

    bpri_pkg::in_item_t  item;
    bpri_pkg::msg_t      msg;
    bpri_pkg::out_item_t out_item;
    logic                in_ready;
    logic                accept;
    logic                word_valid;
    logic                rx_rd_en;
    logic [RX_AW-1:0]    rx_rd_addr;
    logic [8:0]          rx_rd_data;
    logic                out_valid;

    assign item = request.payload;
    assign accept = request.valid && in_ready;
    assign word_valid = accept && (item.command == bpri_pkg::CMD_WORD);

    bpri_framer #(
        .MSG_WORDS (MSG_WORDS)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (item.bus_word),
        .rd_en      (rx_rd_en),
        .rd_addr    (rx_rd_addr),
        .rd_data    (rx_rd_data),
        .msg        (msg)
    );

    bpri_engine #(
        .MSG_WORDS (MSG_WORDS),
        .NUM_PAGES (NUM_PAGES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .in_ready   (in_ready),
        .msg        (msg),
        .rx_rd_en   (rx_rd_en),
        .rx_rd_addr (rx_rd_addr),
        .rx_rd_data (rx_rd_data),
        .out_valid  (out_valid),
        .out_item   (out_item),
        .out_ready  (result.ready)
    );

    assign request.ready = in_ready;
    assign result.valid = out_valid;
    assign result.payload = out_item;

endmodule

// File: dv/tb_bus_panel_reply_injector_core.sv
// testbench for bus_panel_reply_injector_core: directed and random traffic against a shadow model
`timescale 1ns / 100ps

module tb_bus_panel_reply_injector_core;

    localparam int MSG_WORDS = 32;
    localparam int NUM_PAGES = 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_GAP = 30;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;

    // "changed" replies to a poll, word 0 in the lowest slot
    localparam logic [bpri_pkg::POLL_LEN-1:0][8:0] TFT_CHANGED =
        {9'h06D, 9'h010, 9'h082, 9'h002, 9'h002, bpri_pkg::DEST_WORD};
    localparam logic [bpri_pkg::POLL_LEN-1:0][8:0] LED_CHANGED =
        {9'h07D, 9'h010, 9'h092, 9'h002, 9'h002, bpri_pkg::DEST_WORD};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpri_in_if  req_if ();
    bpri_out_if res_if ();

    bus_panel_reply_injector_core #(
        .MSG_WORDS(MSG_WORDS),
        .NUM_PAGES(NUM_PAGES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_if.sink),
        .result (res_if.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow state of the injector
    logic [8:0] frame_buf [MSG_WORDS];
    int         frame_cnt;
    bit         framing;
    logic [8:0] page_mem [NUM_PAGES*MSG_WORDS];
    bit         speed_req;
    logic [7:0] speed_val;
    bit         panel_known;
    logic [3:0] fan_page;
    logic [4:0] fan_slot;

    bpri_pkg::out_item_t reply_q [$];

    int items_sent = 0;
    int mismatches = 0;
    int hold_left = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int idle_run = 0;

    function automatic void clear_shadow();
        foreach (frame_buf[i]) frame_buf[i] = '0;
        foreach (page_mem[i]) page_mem[i] = '0;
        frame_cnt = 0;
        framing = 1'b0;
        speed_req = 1'b0;
        speed_val = '0;
        panel_known = 1'b0;
        fan_page = bpri_pkg::TFT_PAGE;
        fan_slot = bpri_pkg::TFT_SLOT;
    endfunction

    function automatic void push_reply(logic kind, logic [8:0] data);
        bpri_pkg::out_item_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        r.relay_engaged = speed_req;
        r.panel_detected = panel_known;
        reply_q.push_back(r);
    endfunction

    function automatic void stream_fan_page();
        int base;
        int pos;
        logic [7:0] sum;
        if (int'(fan_page) >= NUM_PAGES)
            return;
        base = int'(fan_page) * MSG_WORDS;
        pos = 4 + int'(fan_slot);
        page_mem[base] = bpri_pkg::DEST_WORD;
        if (pos < bpri_pkg::PAGE_LEN - 1)
            page_mem[base + pos] = {1'b0, speed_val};
        sum = bpri_pkg::SUM_SEED;
        for (int i = 0; i < bpri_pkg::PAGE_LEN - 1; i++)
            sum ^= page_mem[base + i][7:0];
        page_mem[base + bpri_pkg::PAGE_LEN - 1] = {1'b0, sum};
        for (int i = 0; i < bpri_pkg::PAGE_LEN; i++)
            push_reply(bpri_pkg::KIND_BUS, page_mem[base + i]);
    endfunction

    function automatic void finish_message();
        logic [8:0] msg_kind;
        logic [8:0] addr;
        int base;
        msg_kind = frame_buf[2];
        addr = frame_buf[3];
        if (msg_kind == bpri_pkg::MSG_PAGE_WRITE && int'(addr) < NUM_PAGES * 16
                && frame_buf[1] == bpri_pkg::PAGE_WRITE_LEN)
        begin
            base = int'(addr[8:4]) * MSG_WORDS;
            for (int i = 0; i < bpri_pkg::PAGE_LEN; i++)
                page_mem[base + i] = frame_buf[i];
            // panel type is latched from the first store of the detect page only
            if (addr[8:4] == bpri_pkg::DETECT_PAGE && !panel_known)
            begin
                panel_known = 1'b1;
                if (page_mem[int'(bpri_pkg::DETECT_PAGE) * MSG_WORDS + bpri_pkg::DETECT_WORD]
                        == bpri_pkg::LED_CODE)
                begin
                    fan_page = bpri_pkg::LED_PAGE;
                    fan_slot = bpri_pkg::LED_SLOT;
                end
                else
                begin
                    fan_page = bpri_pkg::TFT_PAGE;
                    fan_slot = bpri_pkg::TFT_SLOT;
                end
            end
        end
        if (!speed_req)
            return;
        if (msg_kind == bpri_pkg::MSG_POLL)
        begin
            for (int i = 0; i < bpri_pkg::POLL_LEN; i++)
                push_reply(bpri_pkg::KIND_BUS,
                           (fan_page == bpri_pkg::TFT_PAGE) ? TFT_CHANGED[i] : LED_CHANGED[i]);
        end
        else if (msg_kind == bpri_pkg::MSG_QUERY && int'(addr) == int'(fan_page) * 16)
        begin
            stream_fan_page();
            speed_req = 1'b0;
        end
    endfunction

    function automatic void take_bus_word(logic [8:0] w);
        if (w == bpri_pkg::START_WORD)
        begin
            frame_cnt = 0;
            framing = 1'b1;
        end
        if (!framing || frame_cnt >= MSG_WORDS)
            return;
        frame_buf[frame_cnt] = w;
        frame_cnt++;
        if (frame_cnt > 1 && frame_cnt == int'(frame_buf[1]) + 4)
            finish_message();
    endfunction

    function automatic void predict_item(bpri_pkg::in_item_t it);
        int before_n;
        bpri_pkg::out_item_t tail;
        logic [8:0] rd;
        before_n = reply_q.size();
        case (it.command)
            bpri_pkg::CMD_WORD:
                take_bus_word(it.bus_word);
            bpri_pkg::CMD_SPEED:
            begin
                speed_req = 1'b1;
                speed_val = it.fan_speed;
            end
            bpri_pkg::CMD_READ:
            begin
                rd = '0;
                if (int'(it.page_select) < NUM_PAGES && int'(it.word_select) < MSG_WORDS)
                    rd = page_mem[int'(it.page_select) * MSG_WORDS + int'(it.word_select)];
                push_reply(bpri_pkg::KIND_READ, rd);
            end
            default:
                ;
        endcase
        if (reply_q.size() > before_n)
        begin
            tail = reply_q[reply_q.size() - 1];
            tail.last = 1'b1;
            reply_q[reply_q.size() - 1] = tail;
        end
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: mismatch in %s, got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
        mismatches++;
    endtask

    function automatic bpri_pkg::in_item_t random_item();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(bpri_pkg::in_item_t)-1:0];
    endfunction

    function automatic logic [8:0] body_word();
        logic [8:0] w;
        do
            w = 9'($urandom_range(511));
        while (w == bpri_pkg::START_WORD);
        return w;
    endfunction

    // one transfer on the request side, then a random sender gap
    task automatic send_item(bpri_pkg::in_item_t it);
        int gap;
        gap = 0;
        req_if.payload <= it;
        req_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_item(it);
        items_sent++;
        while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_word(logic [8:0] w);
        bpri_pkg::in_item_t it;
        it = random_item();
        it.command = bpri_pkg::CMD_WORD;
        it.bus_word = w;
        send_item(it);
    endtask

    task automatic send_speed(logic [7:0] speed);
        bpri_pkg::in_item_t it;
        it = random_item();
        it.command = bpri_pkg::CMD_SPEED;
        it.fan_speed = speed;
        send_item(it);
    endtask

    task automatic send_read(logic [3:0] pg, logic [4:0] wd);
        bpri_pkg::in_item_t it;
        it = random_item();
        it.command = bpri_pkg::CMD_READ;
        it.page_select = pg;
        it.word_select = wd;
        send_item(it);
    endtask

    task automatic send_message(logic [8:0] len, logic [8:0] msg_kind, logic [8:0] addr,
                                int body_n);
        send_word(bpri_pkg::START_WORD);
        send_word(len);
        send_word(msg_kind);
        send_word(addr);
        repeat (body_n) send_word(body_word());
    endtask

    task automatic send_short_msg(logic [8:0] msg_kind, logic [8:0] addr);
        send_message(9'd0, msg_kind, addr, 0);
    endtask

    task automatic send_page_write(logic [8:0] addr, logic [8:0] panel_code);
        send_word(bpri_pkg::START_WORD);
        send_word(bpri_pkg::PAGE_WRITE_LEN);
        send_word(bpri_pkg::MSG_PAGE_WRITE);
        send_word(addr);
        for (int i = 4; i < bpri_pkg::PAGE_LEN; i++)
            send_word((i == bpri_pkg::DETECT_WORD) ? panel_code : body_word());
    endtask

    // sender stays quiet until every expected result has come back
    task automatic wait_replies_done();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reads();
        send_read(4'd0, 5'd0);
        send_read(4'(NUM_PAGES - 1), 5'd31);
        send_read(4'(NUM_PAGES), 5'd0);
        send_read(4'd15, 5'd31);
        send_item('{command: bpri_pkg::CMD_NONE, bus_word: 9'h1FF, fan_speed: 8'hFF,
                    page_select: 4'hF, word_select: 5'h1F});
    endtask

    task automatic test_framing();
        // words before any start are ignored
        send_word(9'h1FF);
        send_word(9'h000);
        // start word inside a message restarts framing
        send_word(bpri_pkg::START_WORD);
        send_word(bpri_pkg::PAGE_WRITE_LEN);
        send_short_msg(bpri_pkg::MSG_POLL, 9'h000);
        // length never reached, excess words dropped once the buffer is full
        send_message(9'd30, bpri_pkg::MSG_POLL, 9'h000, 29);
        // wrong length and out-of-range address are not stored
        send_short_msg(bpri_pkg::MSG_PAGE_WRITE, 9'h020);
        send_page_write(9'(NUM_PAGES * 16), bpri_pkg::LED_CODE);
        send_read(4'd2, 5'd0);
        send_read(4'd0, 5'd3);
    endtask

    task automatic test_tft_reply();
        send_speed(8'hFF);
        send_short_msg(bpri_pkg::MSG_POLL, 9'h1FF);
        send_page_write(9'h00F, 9'h1FF);
        send_short_msg(bpri_pkg::MSG_QUERY, 9'h010);
        send_short_msg(bpri_pkg::MSG_QUERY, 9'h000);
        send_read(4'd0, 5'(4 + bpri_pkg::TFT_SLOT));
        send_read(4'd0, 5'(bpri_pkg::PAGE_LEN - 1));
        // request already served, so nothing comes back
        send_short_msg(bpri_pkg::MSG_POLL, 9'h000);
    endtask

    task automatic test_detect_led();
        send_page_write(9'h020, bpri_pkg::LED_CODE);
        send_speed(8'h00);
        send_short_msg(bpri_pkg::MSG_POLL, 9'h000);
        send_short_msg(bpri_pkg::MSG_QUERY, 9'h000);
        send_short_msg(bpri_pkg::MSG_QUERY, 9'h02A);
        send_short_msg(bpri_pkg::MSG_QUERY, {1'b0, bpri_pkg::LED_PAGE, 4'h0});
        // second store of the detect page leaves the panel type alone
        send_page_write(9'h02F, 9'h000);
        send_speed(8'hA5);
        send_short_msg(bpri_pkg::MSG_POLL, 9'h0AA);
        send_read(4'd2, 5'(bpri_pkg::DETECT_WORD));
    endtask

    task automatic test_random_traffic(int n, int src_pct, int sink_pct);
        int goal;
        int pick;
        logic [8:0] addr;
        bpri_pkg::in_item_t it;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        goal = items_sent + n;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                addr = ($urandom_range(9) != 0) ? 9'($urandom_range(NUM_PAGES * 16 - 1))
                                                : 9'($urandom_range(511, NUM_PAGES * 16));
                send_page_write(addr, $urandom_range(1) ? bpri_pkg::LED_CODE : body_word());
            end
            else if (pick < 40)
                send_speed(8'($urandom));
            else if (pick < 55)
                send_short_msg(bpri_pkg::MSG_POLL, 9'($urandom));
            else if (pick < 72)
            begin
                addr = ($urandom_range(6) != 0) ? {1'b0, fan_page, 4'h0} : 9'($urandom);
                send_short_msg(bpri_pkg::MSG_QUERY, addr);
            end
            else if (pick < 85)
                send_read(4'($urandom), 5'($urandom));
            else if (pick < 92)
            begin
                it = random_item();
                if ($urandom_range(3) == 0)
                begin
                    it.command = bpri_pkg::CMD_WORD;
                    it.bus_word = bpri_pkg::START_WORD;
                end
                send_item(it);
            end
            else
                send_message(9'($urandom_range(40)), 9'($urandom_range(7)), 9'($urandom),
                             $urandom_range(6));
        end
    endtask

    // receiver stops for a long stretch while the sender keeps offering items
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = HOLD_CYCLES;
        send_speed(8'($urandom));
        send_short_msg(bpri_pkg::MSG_QUERY, {1'b0, fan_page, 4'h0});
        send_speed(8'h5A);
        send_short_msg(bpri_pkg::MSG_POLL, 9'h000);
        repeat (4) send_read(4'($urandom), 5'($urandom));
        wait_replies_done();
    endtask

    initial
    begin : result_sink
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        bpri_pkg::out_item_t got;
        bpri_pkg::out_item_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.payload;
            if (reply_q.size() == 0)
                report_mismatch("unexpected result, data", 32'(got.data), 0);
            else
            begin
                want = reply_q.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.data !== want.data)
                    report_mismatch("data", 32'(got.data), 32'(want.data));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
                if (got.relay_engaged !== want.relay_engaged)
                    report_mismatch("relay_engaged", 32'(got.relay_engaged),
                                    32'(want.relay_engaged));
                if (got.panel_detected !== want.panel_detected)
                    report_mismatch("panel_detected", 32'(got.panel_detected),
                                    32'(want.panel_detected));
            end
        end
    end

    // counts cycles without any transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= IDLE_LIMIT)
            begin
                $display("%0t ns: watchdog, no transfer for %0d cycles", $time, idle_run);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        clear_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // no idling
        src_idle_pct = 0;
        sink_stall_pct = 0;
        test_reads();
        test_framing();
        // sender idle most of the time
        src_idle_pct = 64;
        sink_stall_pct = 0;
        test_tft_reply();
        // receiver stalling most of the time
        src_idle_pct = 0;
        sink_stall_pct = 64;
        test_detect_led();
        test_backpressure();
        // both sides idle now and then
        test_random_traffic(16, 21, 21);

        wait_replies_done();
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
            report_mismatch("results never delivered, count", reply_q.size(), 0);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/bpri_pkg.sv
sv/bpri_if.sv
sv/bpri_ram.sv
sv/bpri_framer.sv
sv/bpri_engine.sv
sv/bus_panel_reply_injector_core.sv
dv/tb_bus_panel_reply_injector_core.sv
